@@ rtl/core/slx_pkg.sv @@
// ----------------------------------------------------------------------------
// Source lexer package
// Shared types, codes, character classes and the keyword table.
// ----------------------------------------------------------------------------
package slx_pkg;

   localparam int KW_LEN = 11;
   localparam int KW_NUM = 21;
   localparam int KW_IDX_W = $clog2(KW_LEN);
   localparam int RSLT_NUM = 4;
   localparam logic [15:0] INT_LIMIT = 16'd32767;
   localparam logic [15:0] INT_SAT = 16'd32768;

   localparam logic [7:0] CH_LF = 8'd10;
   localparam logic [7:0] CH_TAB = 8'd9;
   localparam logic [7:0] CH_CR = 8'd13;
   localparam logic [7:0] CH_SPACE = 8'd32;
   localparam logic [7:0] CH_QUOTE = 8'd34;
   localparam logic [7:0] CH_STAR = 8'd42;
   localparam logic [7:0] CH_SLASH = 8'd47;

   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_END = 1'b1;

   typedef enum logic [2:0] {
      MODE_NORMAL,
      MODE_SLASH,
      MODE_LINE,
      MODE_BLOCK,
      MODE_STAR
   } mode_type;

   typedef enum logic [2:0] {
      TT_KEYWORD,
      TT_SYMBOL,
      TT_IDENT,
      TT_INTEGER,
      TT_STRING,
      TT_INVALID
   } ttype_type;

   typedef enum logic [1:0] {
      ERR_NONE,
      ERR_RANGE,
      ERR_INVALID,
      ERR_UNCLOSED
   } err_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  ch_out;
      logic [2:0]  tok_class;
      logic [4:0]  keyword_id;
      logic [14:0] int_value;
      logic [1:0]  error;
      logic        last;
   } rslt_type;

   typedef struct packed {
      logic [4:0]  len;
      logic        ident_ok;
      logic        all_digits;
      logic [15:0] acc;
      logic        in_string;
   } tok_type;

   localparam logic [8*KW_LEN-1:0] KW_TEXT [KW_NUM] = '{
      "class", "constructor", "function", "method", "field", "static", "var",
      "int", "char", "boolean", "void", "true", "false", "null", "this",
      "let", "do", "if", "else", "while", "return"};

   localparam logic [4:0] KW_SIZE [KW_NUM] = '{
      5'd5, 5'd11, 5'd8, 5'd6, 5'd5, 5'd6, 5'd3,
      5'd3, 5'd4, 5'd7, 5'd4, 5'd4, 5'd5, 5'd4, 5'd4,
      5'd3, 5'd2, 5'd2, 5'd4, 5'd5, 5'd6};

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_CR;
   endfunction

   function automatic logic is_symbol(input logic [7:0] c);
      return c == "{" || c == "}" || c == "(" || c == ")" || c == "[" ||
         c == "]" || c == "." || c == "," || c == ";" || c == "+" ||
         c == "-" || c == "*" || c == "&" || c == "|" || c == "<" ||
         c == ">" || c == "=" || c == "~";
   endfunction

   // Returns {hit, id}.
   function automatic logic [5:0] kw_match(input logic [7:0] kbuf [KW_LEN],
                                           input logic [4:0] len);
      logic [5:0] res;
      logic       ok;
      int         pos;
      res = '0;
      for (int k = KW_NUM - 1; k >= 0; k--) begin
         ok = (len == KW_SIZE[k]);
         for (int i = 0; i < KW_LEN; i++) begin
            pos = int'(KW_SIZE[k]) - 1 - i;
            if (pos >= 0) begin
               if (kbuf[i] != KW_TEXT[k][8*pos +: 8]) begin
                  ok = 1'b0;
               end
            end
         end
         if (ok) begin
            res = {1'b1, 5'(k)};
         end
      end
      return res;
   endfunction

endpackage

@@ rtl/core/source_lexer_stream.sv @@
// ----------------------------------------------------------------------------
// Source lexer stream
// Streaming tokenizer that strips comments and classifies tokens.
// ----------------------------------------------------------------------------
// One source byte enters per req_ handshake; req_end_of_source flushes the
// pending token as a line end would. Each byte yields zero to four rsp_
// items: echoed token characters (kind 0) and token ends with a class,
// keyword id, integer value and error code (kind 1). rsp_last marks the
// final item caused by one input byte.
// A byte is decoded in the cycle it is accepted and its items are held in a
// four-entry result buffer, so the first item is valid in the cycle after the
// byte is accepted. The buffer drains one item per cycle while rsp_ready is
// high; a new byte is taken when the buffer is empty or its last item is
// being taken, so with rsp_ready high, bytes that give at most one item flow
// at one per cycle, and a byte with more items holds off the next byte.
// Reset returns the scanner to normal mode with no token pending and empties
// the result buffer. When the receiver stalls, the current item holds and
// req_ready drops once the buffer still holds items after this cycle.
// ----------------------------------------------------------------------------
module source_lexer_stream (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_ch,
   input  logic        req_end_of_source,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [7:0]  rsp_ch_out,
   output logic [2:0]  rsp_tok_class,
   output logic [4:0]  rsp_keyword_id,
   output logic [14:0] rsp_int_value,
   output logic [1:0]  rsp_error,
   output logic        rsp_last
);

   slx_pkg::mode_type                mode_ff;
   slx_pkg::mode_type                mode_in;
   slx_pkg::tok_type                 tok_ff;
   slx_pkg::tok_type                 tok_in;
   logic [7:0]                       kbuf_ff [slx_pkg::KW_LEN];
   slx_pkg::rslt_type                rbuf_ff [slx_pkg::RSLT_NUM];
   slx_pkg::rslt_type                rslt_in [slx_pkg::RSLT_NUM];
   logic [2:0]                       cnt_ff;
   logic [2:0]                       cnt_in;
   logic [1:0]                       rd_ff;
   logic                             wr_en;
   logic [slx_pkg::KW_IDX_W-1:0]     wr_idx;
   logic [7:0]                       wr_data;
   logic                             req_fire;
   logic                             rsp_fire;
   slx_pkg::rslt_type                cur;

   slx_step u_step (
      .ch       (req_ch),
      .eos      (req_end_of_source),
      .mode     (mode_ff),
      .tok      (tok_ff),
      .kbuf     (kbuf_ff),
      .mode_nxt (mode_in),
      .tok_nxt  (tok_in),
      .wr_en    (wr_en),
      .wr_idx   (wr_idx),
      .wr_data  (wr_data),
      .rslt     (rslt_in),
      .count    (cnt_in)
   );

   assign rsp_valid = (cnt_ff != '0);
   assign rsp_fire = rsp_valid && rsp_ready;
   assign req_ready = (cnt_ff == '0) || (cnt_ff == 3'd1 && rsp_ready);
   assign req_fire = req_valid && req_ready;

   assign cur = rbuf_ff[rd_ff];
   assign rsp_kind = cur.kind;
   assign rsp_ch_out = cur.ch_out;
   assign rsp_tok_class = cur.tok_class;
   assign rsp_keyword_id = cur.keyword_id;
   assign rsp_int_value = cur.int_value;
   assign rsp_error = cur.error;
   assign rsp_last = cur.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= slx_pkg::MODE_NORMAL;
         tok_ff <= '0;
         cnt_ff <= '0;
         rd_ff <= '0;
      end else if (req_fire) begin
         mode_ff <= mode_in;
         tok_ff <= tok_in;
         cnt_ff <= cnt_in;
         rd_ff <= '0;
      end else if (rsp_fire) begin
         cnt_ff <= cnt_ff - 3'd1;
         rd_ff <= rd_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rbuf_ff <= rslt_in;
         for (int i = 0; i < slx_pkg::KW_LEN; i++) begin
            if (wr_en && wr_idx == slx_pkg::KW_IDX_W'(i)) begin
               kbuf_ff[i] <= wr_data;
            end
         end
      end
   end

endmodule

@@ rtl/core/slx_step.sv @@
// ----------------------------------------------------------------------------
// Source lexer step
// Works out the results of one source byte and the next scanner state.
// ----------------------------------------------------------------------------
module slx_step (
   input  logic [7:0]                     ch,
   input  logic                           eos,
   input  slx_pkg::mode_type              mode,
   input  slx_pkg::tok_type               tok,
   input  logic [7:0]                     kbuf [slx_pkg::KW_LEN],
   output slx_pkg::mode_type              mode_nxt,
   output slx_pkg::tok_type               tok_nxt,
   output logic                           wr_en,
   output logic [slx_pkg::KW_IDX_W-1:0]   wr_idx,
   output logic [7:0]                     wr_data,
   output slx_pkg::rslt_type              rslt [slx_pkg::RSLT_NUM],
   output logic [2:0]                     count
);

   logic              proc;
   logic              slash_rel;
   logic              word_end;
   logic              unclosed;
   logic              add;
   logic              sym_end;
   logic              str_end;
   logic              str_open;
   logic [5:0]        kw;
   logic [18:0]       prod;
   slx_pkg::tok_type  base;
   slx_pkg::tok_type  added;
   slx_pkg::rslt_type cand [5];
   logic [4:0]        cand_v;
   logic [2:0]        n;

   always_comb begin
      proc = 1'b0;
      slash_rel = 1'b0;
      word_end = 1'b0;
      unclosed = 1'b0;
      add = 1'b0;
      sym_end = 1'b0;
      str_end = 1'b0;
      str_open = 1'b0;
      mode_nxt = mode;
      if (eos || ch == slx_pkg::CH_LF) begin
         slash_rel = (mode == slx_pkg::MODE_SLASH);
         if (mode == slx_pkg::MODE_STAR || mode == slx_pkg::MODE_BLOCK) begin
            mode_nxt = slx_pkg::MODE_BLOCK;
         end else begin
            mode_nxt = slx_pkg::MODE_NORMAL;
         end
         if (tok.in_string) begin
            unclosed = 1'b1;
         end else begin
            word_end = 1'b1;
         end
      end else begin
         unique case (mode)
            slx_pkg::MODE_LINE: begin
            end
            slx_pkg::MODE_BLOCK: begin
               if (ch == slx_pkg::CH_STAR) begin
                  mode_nxt = slx_pkg::MODE_STAR;
               end
            end
            slx_pkg::MODE_STAR: begin
               if (ch == slx_pkg::CH_SLASH) begin
                  mode_nxt = slx_pkg::MODE_NORMAL;
               end else if (ch != slx_pkg::CH_STAR) begin
                  mode_nxt = slx_pkg::MODE_BLOCK;
               end
            end
            slx_pkg::MODE_SLASH: begin
               if (ch == slx_pkg::CH_SLASH) begin
                  mode_nxt = slx_pkg::MODE_LINE;
               end else if (ch == slx_pkg::CH_STAR) begin
                  mode_nxt = slx_pkg::MODE_BLOCK;
               end else begin
                  slash_rel = 1'b1;
                  mode_nxt = slx_pkg::MODE_NORMAL;
                  proc = 1'b1;
               end
            end
            default: begin
               mode_nxt = slx_pkg::MODE_NORMAL;
               proc = 1'b1;
            end
         endcase
      end
      if (proc) begin
         priority if (tok.in_string) begin
            add = 1'b1;
            str_open = 1'b1;
            str_end = (ch == slx_pkg::CH_QUOTE);
         end else if (slx_pkg::is_blank(ch)) begin
            word_end = 1'b1;
         end else if (ch == slx_pkg::CH_SLASH) begin
            word_end = 1'b1;
            mode_nxt = slx_pkg::MODE_SLASH;
         end else if (slx_pkg::is_symbol(ch)) begin
            word_end = 1'b1;
            sym_end = 1'b1;
         end else if (ch == slx_pkg::CH_QUOTE) begin
            word_end = 1'b1;
            add = 1'b1;
            str_open = 1'b1;
         end else begin
            add = 1'b1;
         end
      end
   end

   always_comb begin
      base = (word_end || unclosed) ? '0 : tok;
      added = base;
      prod = 19'(base.acc) * 19'd10 + 19'(ch - "0");
      if (base.len == '0) begin
         added.ident_ok = slx_pkg::is_alpha(ch);
         added.all_digits = slx_pkg::is_digit(ch);
         added.acc = '0;
         prod = 19'(ch - "0");
      end else begin
         if (!(slx_pkg::is_alpha(ch) || slx_pkg::is_digit(ch))) begin
            added.ident_ok = 1'b0;
         end
         if (!slx_pkg::is_digit(ch)) begin
            added.all_digits = 1'b0;
         end
      end
      if (slx_pkg::is_digit(ch)) begin
         added.acc = (prod > 19'(slx_pkg::INT_SAT)) ? slx_pkg::INT_SAT : prod[15:0];
      end
      if (base.len != 5'd31) begin
         added.len = base.len + 5'd1;
      end
      added.in_string = str_open;
      if (!add || str_end) begin
         tok_nxt = add ? '0 : base;
      end else begin
         tok_nxt = added;
      end
      wr_en = add && (base.len < 5'(slx_pkg::KW_LEN));
      wr_idx = base.len[slx_pkg::KW_IDX_W-1:0];
      wr_data = ch;
   end

   always_comb begin
      kw = slx_pkg::kw_match(kbuf, tok.len);
      for (int j = 0; j < 5; j++) begin
         cand[j] = '0;
      end
      cand[0].kind = slx_pkg::KIND_CHAR;
      cand[0].ch_out = slx_pkg::CH_SLASH;
      cand[1].kind = slx_pkg::KIND_END;
      cand[1].tok_class = slx_pkg::TT_SYMBOL;
      cand[2].kind = slx_pkg::KIND_END;
      if (unclosed) begin
         cand[2].tok_class = slx_pkg::TT_INVALID;
         cand[2].error = slx_pkg::ERR_UNCLOSED;
      end else if (kw[5]) begin
         cand[2].tok_class = slx_pkg::TT_KEYWORD;
         cand[2].keyword_id = kw[4:0];
      end else if (tok.ident_ok) begin
         cand[2].tok_class = slx_pkg::TT_IDENT;
      end else if (tok.all_digits && tok.acc <= slx_pkg::INT_LIMIT) begin
         cand[2].tok_class = slx_pkg::TT_INTEGER;
         cand[2].int_value = tok.acc[14:0];
      end else if (tok.all_digits) begin
         cand[2].tok_class = slx_pkg::TT_INVALID;
         cand[2].error = slx_pkg::ERR_RANGE;
      end else begin
         cand[2].tok_class = slx_pkg::TT_INVALID;
         cand[2].error = slx_pkg::ERR_INVALID;
      end
      cand[3].kind = slx_pkg::KIND_CHAR;
      cand[3].ch_out = ch;
      cand[4].kind = slx_pkg::KIND_END;
      cand[4].tok_class = sym_end ? slx_pkg::TT_SYMBOL : slx_pkg::TT_STRING;
      cand_v = {sym_end || str_end, add || sym_end,
                unclosed || (word_end && tok.len != '0), slash_rel, slash_rel};
      for (int j = 0; j < slx_pkg::RSLT_NUM; j++) begin
         rslt[j] = '0;
      end
      n = '0;
      for (int j = 0; j < 5; j++) begin
         if (cand_v[j]) begin
            rslt[n[1:0]] = cand[j];
            n = n + 3'd1;
         end
      end
      if (n != '0) begin
         rslt[2'(n - 3'd1)].last = 1'b1;
      end
      count = n;
   end

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// Source lexer stream testbench
// Feeds source bytes through valid/ready with random gaps and receiver stalls,
// predicts the echoed characters and token ends of each byte and compares
// every result item field by field in order.
// ----------------------------------------------------------------------------
module testbench;

   typedef struct packed {
      logic [7:0] ch;
      logic       eos;
   } src_item_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  ch_out;
      logic [2:0]  tok_class;
      logic [4:0]  keyword_id;
      logic [14:0] int_value;
      logic [1:0]  error;
      logic        last;
   } tok_rslt_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_ch = '0;
   logic        req_end_of_source = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_kind;
   logic [7:0]  rsp_ch_out;
   logic [2:0]  rsp_tok_class;
   logic [4:0]  rsp_keyword_id;
   logic [14:0] rsp_int_value;
   logic [1:0]  rsp_error;
   logic        rsp_last;

   source_lexer_stream uut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   src_item_type pending_bytes[$];
   tok_rslt_type expected_tokens[$];
   int        fail_count = 0;
   bit        stim_done = 0;
   int        gap_left = 0;
   int        hold_left = 0;
   int        long_hold_at = 120;
   int        bytes_sent = 0;

   // Lexer shadow state.
   slx_pkg::mode_type lx_mode;
   logic       lx_in_str;
   logic [4:0] lx_len;
   logic [7:0] lx_kbuf [slx_pkg::KW_LEN];
   logic       lx_ident;
   logic       lx_digits;
   logic [15:0] lx_acc;
   tok_rslt_type step_out[$];

   string kw_words[slx_pkg::KW_NUM] = '{"class", "constructor", "function", "method",
      "field", "static", "var", "int", "char", "boolean", "void", "true",
      "false", "null", "this", "let", "do", "if", "else", "while", "return"};

   function automatic bit digit_c(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit alpha_c(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
   endfunction

   function automatic bit symbol_c(logic [7:0] c);
      string s;
      s = "{}()[].,;+-*&|<>=~";
      for (int i = 0; i < s.len(); i++) if (s[i] == c) return 1;
      return 0;
   endfunction

   function automatic void put_rslt(logic k, logic [7:0] c, slx_pkg::ttype_type t,
                                    logic [4:0] id, logic [14:0] v,
                                    slx_pkg::err_type e);
      tok_rslt_type r;
      r = '{k, c, t, id, v, e, 1'b0};
      step_out.insert(step_out.size(), r);
   endfunction

   function automatic void clear_token();
      lx_len = 0; lx_ident = 0; lx_digits = 0; lx_acc = 0; lx_in_str = 0;
   endfunction

   function automatic void add_char(logic [7:0] c);
      int v;
      put_rslt(slx_pkg::KIND_CHAR, c, slx_pkg::TT_KEYWORD, 0, 0, slx_pkg::ERR_NONE);
      if (lx_len < slx_pkg::KW_LEN) lx_kbuf[lx_len] = c;
      if (lx_len == 0) begin
         lx_ident = alpha_c(c);
         lx_digits = digit_c(c);
         lx_acc = 0;
      end else begin
         if (!(alpha_c(c) || digit_c(c))) lx_ident = 0;
         if (!digit_c(c)) lx_digits = 0;
      end
      if (digit_c(c)) begin
         v = lx_acc * 10 + (c - "0");
         lx_acc = (v > 32768) ? 16'd32768 : 16'(v);
      end
      if (lx_len < 31) lx_len++;
   endfunction

   function automatic void finish_token();
      int hit;
      bit ok;
      hit = -1;
      if (lx_len == 0) begin
         clear_token();
         return;
      end
      for (int k = 0; k < slx_pkg::KW_NUM && hit < 0; k++) begin
         if (kw_words[k].len() == lx_len && lx_len <= slx_pkg::KW_LEN) begin
            ok = 1;
            for (int i = 0; i < lx_len; i++)
               if (lx_kbuf[i] != kw_words[k][i]) ok = 0;
            if (ok) hit = k;
         end
      end
      if (hit >= 0)
         put_rslt(slx_pkg::KIND_END, 0, slx_pkg::TT_KEYWORD, 5'(hit), 0, slx_pkg::ERR_NONE);
      else if (lx_ident)
         put_rslt(slx_pkg::KIND_END, 0, slx_pkg::TT_IDENT, 0, 0, slx_pkg::ERR_NONE);
      else if (lx_digits && lx_acc <= slx_pkg::INT_LIMIT)
         put_rslt(slx_pkg::KIND_END, 0, slx_pkg::TT_INTEGER, 0, lx_acc[14:0],
                  slx_pkg::ERR_NONE);
      else if (lx_digits)
         put_rslt(slx_pkg::KIND_END, 0, slx_pkg::TT_INVALID, 0, 0, slx_pkg::ERR_RANGE);
      else
         put_rslt(slx_pkg::KIND_END, 0, slx_pkg::TT_INVALID, 0, 0, slx_pkg::ERR_INVALID);
      clear_token();
   endfunction

   function automatic void symbol_token(logic [7:0] c);
      put_rslt(slx_pkg::KIND_CHAR, c, slx_pkg::TT_KEYWORD, 0, 0, slx_pkg::ERR_NONE);
      put_rslt(slx_pkg::KIND_END, 0, slx_pkg::TT_SYMBOL, 0, 0, slx_pkg::ERR_NONE);
   endfunction

   function automatic void plain_char(logic [7:0] c);
      if (lx_in_str) begin
         add_char(c);
         if (c == slx_pkg::CH_QUOTE) begin
            put_rslt(slx_pkg::KIND_END, 0, slx_pkg::TT_STRING, 0, 0, slx_pkg::ERR_NONE);
            clear_token();
         end
      end else if (c == slx_pkg::CH_SPACE || c == slx_pkg::CH_TAB ||
                   c == slx_pkg::CH_CR) begin
         finish_token();
      end else if (c == slx_pkg::CH_SLASH) begin
         finish_token();
         lx_mode = slx_pkg::MODE_SLASH;
      end else if (symbol_c(c)) begin
         finish_token();
         symbol_token(c);
      end else if (c == slx_pkg::CH_QUOTE) begin
         finish_token();
         lx_in_str = 1;
         add_char(c);
      end else begin
         add_char(c);
      end
   endfunction

   function automatic void predict_byte(src_item_type it);
      step_out.delete();
      if (it.eos || it.ch == slx_pkg::CH_LF) begin
         case (lx_mode)
            slx_pkg::MODE_SLASH: begin
               symbol_token(slx_pkg::CH_SLASH);
               lx_mode = slx_pkg::MODE_NORMAL;
            end
            slx_pkg::MODE_LINE: lx_mode = slx_pkg::MODE_NORMAL;
            slx_pkg::MODE_STAR: lx_mode = slx_pkg::MODE_BLOCK;
            slx_pkg::MODE_BLOCK: ;
            default: lx_mode = slx_pkg::MODE_NORMAL;
         endcase
         if (lx_in_str) begin
            put_rslt(slx_pkg::KIND_END, 0, slx_pkg::TT_INVALID, 0, 0, slx_pkg::ERR_UNCLOSED);
            clear_token();
         end else begin
            finish_token();
         end
      end else begin
         case (lx_mode)
            slx_pkg::MODE_LINE: ;
            slx_pkg::MODE_BLOCK: if (it.ch == slx_pkg::CH_STAR) lx_mode = slx_pkg::MODE_STAR;
            slx_pkg::MODE_STAR: begin
               if (it.ch == slx_pkg::CH_SLASH) lx_mode = slx_pkg::MODE_NORMAL;
               else if (it.ch != slx_pkg::CH_STAR) lx_mode = slx_pkg::MODE_BLOCK;
            end
            slx_pkg::MODE_SLASH: begin
               if (it.ch == slx_pkg::CH_SLASH) lx_mode = slx_pkg::MODE_LINE;
               else if (it.ch == slx_pkg::CH_STAR) lx_mode = slx_pkg::MODE_BLOCK;
               else begin
                  symbol_token(slx_pkg::CH_SLASH);
                  lx_mode = slx_pkg::MODE_NORMAL;
                  plain_char(it.ch);
               end
            end
            default: begin
               lx_mode = slx_pkg::MODE_NORMAL;
               plain_char(it.ch);
            end
         endcase
      end
      if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
      foreach (step_out[i]) expected_tokens.insert(expected_tokens.size(), step_out[i]);
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Driver.
   always @(posedge clock) begin
      src_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_byte('{req_ch, req_end_of_source});
            bytes_sent++;
         end
         if (req_valid && !req_ready) begin
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_bytes.size() > 0) begin
            nxt = pending_bytes.pop_front();
            req_valid <= 1'b1;
            req_ch <= nxt.ch;
            req_end_of_source <= nxt.eos;
            gap_left = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor and receiver stalls.
   always @(posedge clock) begin
      tok_rslt_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_tokens.size() == 0) begin
               $error("unexpected item kind=%0d ch_out=%0d", rsp_kind, rsp_ch_out);
               fail_count++;
            end else begin
               e = expected_tokens.pop_front();
               if (rsp_kind !== e.kind) begin
                  $error("kind exp %0d got %0d", e.kind, rsp_kind); fail_count++;
               end
               if (rsp_ch_out !== e.ch_out) begin
                  $error("ch_out exp %0d got %0d", e.ch_out, rsp_ch_out); fail_count++;
               end
               if (rsp_tok_class !== e.tok_class) begin
                  $error("tok_class exp %0d got %0d", e.tok_class, rsp_tok_class);
                  fail_count++;
               end
               if (rsp_keyword_id !== e.keyword_id) begin
                  $error("keyword_id exp %0d got %0d", e.keyword_id, rsp_keyword_id);
                  fail_count++;
               end
               if (rsp_int_value !== e.int_value) begin
                  $error("int_value exp %0d got %0d", e.int_value, rsp_int_value);
                  fail_count++;
               end
               if (rsp_error !== e.error) begin
                  $error("error exp %0d got %0d", e.error, rsp_error); fail_count++;
               end
               if (rsp_last !== e.last) begin
                  $error("last exp %0d got %0d", e.last, rsp_last); fail_count++;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (long_hold_at >= 0 && bytes_sent >= long_hold_at) begin
            long_hold_at = -1;
            hold_left = 60;
            rsp_ready <= 1'b0;
         end else if (bytes_sent > 200 && bytes_sent < 240) begin
            rsp_ready <= 1'b1;
         end else begin
            hold_left = pick_gap();
            rsp_ready <= (hold_left == 0);
         end
      end
   end

   task automatic push_byte(logic [7:0] b, logic eos);
      src_item_type it;
      it = '{b, eos};
      pending_bytes.insert(pending_bytes.size(), it);
   endtask

   task automatic push_text(string s);
      foreach (s[i]) push_byte(s[i], 1'b0);
   endtask

   task automatic push_eos();
      push_byte(8'($urandom_range(0, 255)), 1'b1);
   endtask

   function automatic string random_token();
      string s;
      int n;
      case ($urandom_range(0, 7))
         0, 1: return kw_words[$urandom_range(0, slx_pkg::KW_NUM - 1)];
         2: return $sformatf("%0d", $urandom_range(0, 40000));
         3: begin
            s = "x";
            n = $urandom_range(1, 13);
            for (int i = 0; i < n; i++)
               s = {s, string'(8'("a" + $urandom_range(0, 25)))};
            return s;
         end
         4: return "\"a /* b // c\"";
         5: return "/* c\n*/";
         6: return "// note";
         default: begin
            s = "{}()[].,;+-*&|<>=~/";
            n = $urandom_range(0, 18);
            return s.substr(n, n);
         end
      endcase
   endfunction

   initial begin
      string blanks;
      logic [7:0] b;
      blanks = " \t\r\n";
      lx_mode = slx_pkg::MODE_NORMAL;
      clear_token();
      foreach (lx_kbuf[i]) lx_kbuf[i] = '0;
      push_text("class constructor q_9 32767 32768 ");
      push_text("a/b//x\n/*/ */ /**/ 7/");
      push_eos();
      push_text("\"s // t\"x\"open\n");
      push_byte(8'd200, 1'b0);
      push_byte(8'd1, 1'b0);
      push_byte(slx_pkg::CH_SPACE, 1'b0);
      push_byte(8'd255, 1'b0);
      push_byte(8'd0, 1'b0);
      push_byte(slx_pkg::CH_LF, 1'b0);
      push_text("returnx abcdefghijkl 99999999999999999999999999999999999\n");
      push_text("/*a\n*b**/return");
      push_eos();
      while (pending_bytes.size() < 300) begin
         if ($urandom_range(0, 9) == 0) begin
            b = 8'($urandom_range(0, 255));
            push_byte(b, 1'($urandom_range(0, 1) == 0 && b[0]));
         end else begin
            push_text(random_token());
            b = 8'(blanks[$urandom_range(0, 3)]);
            push_byte(b, 1'b0);
         end
      end
      push_eos();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      wait (pending_bytes.size() == 0 && !req_valid);
      wait (expected_tokens.size() == 0);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && expected_tokens.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #10000000;
      $display("Test completed with failures");
      $finish;
   end
endmodule

@@ filelist.f @@
rtl/core/slx_pkg.sv
rtl/core/slx_step.sv
rtl/core/source_lexer_stream.sv
tb/sv/testbench.sv
